@@ design/block_bitmap_allocator_assert.svh @@
// Assertion macros shared by the allocator RTL.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/bba_pkg.sv @@
package bba_pkg;

	localparam int BLK_IN_W = 15;
	localparam int GRANT_W  = 16;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_ALLOCATED = 2'd0,
		ST_FULL      = 2'd1,
		ST_FREED     = 2'd2,
		ST_REJECTED  = 2'd3
	} status_t;

	typedef struct packed {
		opcode_t               opcode;
		logic [BLK_IN_W-1:0]   blk_num;
	} req_t;

	typedef struct packed {
		logic [GRANT_W-1:0]    granted_block;
		status_t               status;
	} rsp_t;

endpackage

@@ design/bba_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/block_bitmap_allocator.sv @@
// First-fit block allocator over a used/free bitmap held in a RAM of BLOCKS/WORD_BITS words.
// An allocate beat scans upward from first_data_block and grants the lowest free block,
// marking it used; when none is free it answers status 1 with granted_block equal to BLOCKS
// (low 16 bits). A free beat clears the bit of the named block (status 2) or, when the
// number lies at or past BLOCKS, changes nothing and answers status 3; every free answers
// granted_block equal to BLOCKS. After reset the block first walks the whole RAM writing
// zeros, one word per cycle, and req_ready stays low until that pass ends. Each request is
// then handled alone: a free passes through the division states, reads the bitmap word and
// writes it back, and an allocate passes through the division states and then the scan.
// The scan rate is one word per cycle, set by the single read port of the bitmap RAM; the
// start word and bit offset are found by a reciprocal multiply with one correction step in
// states S_DIV1 to S_DIV3. The result sits in an output register, and a new request is taken
// as soon as the previous one has been placed there. The user must write first_data_block
// through cfg_we/cfg_wdata only while idle; the block itself does not enforce this.
`include "block_bitmap_allocator_assert.svh"

module block_bitmap_allocator
	import bba_pkg::*;
#(
	parameter int BLOCKS    = 32768,
	parameter int WORD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  req_t                req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output rsp_t                rsp,
	input  logic                cfg_we,
	input  logic [BLK_IN_W-1:0] cfg_wdata
);

	// Bitmap geometry.
	localparam int NWORDS = (BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int OW     = $clog2(WORD_BITS);
	// Block numbers during the scan may run one word past BLOCKS, and must hold any 15-bit
	// start value as well.
	localparam int BW_RAW = $clog2(BLOCKS + 2 * WORD_BITS);
	localparam int BW     = (BW_RAW > GRANT_W) ? BW_RAW : GRANT_W;

	// Division of a 15-bit block number by WORD_BITS: the quotient estimate
	// (x * floor(2^15 / WORD_BITS)) >> 15 is either exact or one too small.
	localparam int DSH   = BLK_IN_W;
	localparam int RECIP = (1 << DSH) / WORD_BITS;
	localparam int MW    = $clog2(RECIP + 1);
	localparam int PW    = BLK_IN_W + MW;
	localparam int QWW   = MW + $clog2(WORD_BITS + 1);

	localparam logic [BW-1:0]      BLOCKS_B   = BW'(BLOCKS);
	localparam logic [GRANT_W-1:0] GRANT_NONE = GRANT_W'(BLOCKS);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV1,
		S_DIV2,
		S_DIV3,
		S_SCAN,
		S_FREE_RD,
		S_FREE_WR,
		S_RESP
	} state_t;

	state_t                state_q;
	logic [AW-1:0]         clr_q;
	logic [BLK_IN_W-1:0]   fdb_q;
	opcode_t               op_q;
	logic [BLK_IN_W-1:0]   x_q;
	logic [PW-1:0]         prod_q;
	logic [MW-1:0]         q0_q;
	logic [QWW-1:0]        qw_q;
	logic [OW-1:0]         off_q;
	logic                  first_q;
	logic [AW-1:0]         rd_word_q;
	logic [BW-1:0]         rd_base_q;
	logic                  chk_valid_s1;
	logic                  chk_first_s1;
	logic [AW-1:0]         chk_word_s1;
	logic [BW-1:0]         chk_base_s1;
	rsp_t                  res_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	// Remainder correction for the start position.
	logic [GRANT_W-1:0]    r_raw;
	logic [OW-1:0]         off_c;
	logic [MW-1:0]         q_c;
	logic [BW-1:0]         base_c;
	logic                  out_of_range;

	// Scan check on the word just read.
	logic [WORD_BITS-1:0]  ram_rdata;
	logic [WORD_BITS-1:0]  low_mask;
	logic [WORD_BITS-1:0]  free_bits;
	logic                  found;
	logic [OW-1:0]         pos;
	logic [BW-1:0]         cand;
	logic                  cand_ok;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [WORD_BITS-1:0]  ram_wdata;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The configuration register is independent of the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fdb_q <= '0;
		end else if (cfg_we) begin
			fdb_q <= cfg_wdata;
		end
	end

	// The estimate never exceeds the true quotient, so the raw remainder is below
	// twice the word size and one compare and subtract finishes the division.
	always_comb begin
		r_raw        = {1'b0, x_q} - GRANT_W'(qw_q);
		if (r_raw >= GRANT_W'(WORD_BITS)) begin
			off_c = OW'(r_raw - GRANT_W'(WORD_BITS));
			q_c   = q0_q + 1'b1;
		end else begin
			off_c = OW'(r_raw);
			q_c   = q0_q;
		end
		base_c       = BW'(x_q) - BW'(off_c);
		out_of_range = (BW'(x_q) >= BLOCKS_B);
	end

	// Lowest clear bit of the word under check. In the first word of a scan the
	// bits below the start offset count as used.
	always_comb begin
		low_mask  = chk_first_s1 ? ((WORD_BITS'(1) << off_q) - WORD_BITS'(1)) : '0;
		free_bits = ~(ram_rdata | low_mask);
		found     = |free_bits;
		pos       = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				pos = OW'(i);
			end
		end
		cand    = chk_base_s1 + BW'(pos);
		cand_ok = (cand < BLOCKS_B);
	end

	// Bitmap RAM write port: clearing pass, setting a granted bit, clearing a freed bit.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rd_word_q;
		ram_wdata = ram_rdata & ~(WORD_BITS'(1) << off_q);
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_SCAN: begin
				ram_we    = chk_valid_s1 && found && cand_ok;
				ram_waddr = chk_word_s1;
				ram_wdata = ram_rdata | (WORD_BITS'(1) << pos);
			end
			S_FREE_WR: begin
				ram_we    = 1'b1;
			end
			default: begin
				ram_we    = 1'b0;
			end
		endcase
	end

	bba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(NWORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_word_q),
		.rdata (ram_rdata)
	);

	// Sequencer. In S_SCAN a read is issued each cycle while the word read in the
	// previous cycle is checked, so the scan advances one word per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			op_q         <= OP_ALLOC;
			x_q          <= '0;
			prod_q       <= '0;
			q0_q         <= '0;
			qw_q         <= '0;
			off_q        <= '0;
			first_q      <= 1'b0;
			rd_word_q    <= '0;
			rd_base_q    <= '0;
			chk_valid_s1 <= 1'b0;
			chk_first_s1 <= 1'b0;
			chk_word_s1  <= '0;
			chk_base_s1  <= '0;
			res_q        <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			// A taken output beat drops valid; in S_RESP the load below decides instead.
			if (rsp_ready && state_q != S_RESP) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(NWORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						op_q    <= req.opcode;
						x_q     <= (req.opcode == OP_ALLOC) ? fdb_q : req.blk_num;
						state_q <= S_DIV1;
					end
				end
				S_DIV1: begin
					prod_q  <= PW'(x_q) * PW'(RECIP);
					state_q <= S_DIV2;
				end
				S_DIV2: begin
					q0_q    <= MW'(prod_q >> DSH);
					qw_q    <= QWW'(prod_q >> DSH) * QWW'(WORD_BITS);
					state_q <= S_DIV3;
				end
				S_DIV3: begin
					off_q        <= off_c;
					rd_word_q    <= AW'(q_c);
					rd_base_q    <= base_c;
					first_q      <= 1'b1;
					chk_valid_s1 <= 1'b0;
					if (out_of_range) begin
						res_q.granted_block <= GRANT_NONE;
						res_q.status        <= (op_q == OP_ALLOC) ? ST_FULL : ST_REJECTED;
						state_q             <= S_RESP;
					end else if (op_q == OP_ALLOC) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_FREE_RD;
					end
				end
				S_SCAN: begin
					if (chk_valid_s1 && found) begin
						chk_valid_s1 <= 1'b0;
						if (cand_ok) begin
							res_q.granted_block <= GRANT_W'(cand);
							res_q.status        <= ST_ALLOCATED;
						end else begin
							res_q.granted_block <= GRANT_NONE;
							res_q.status        <= ST_FULL;
						end
						state_q <= S_RESP;
					end else if (rd_base_q >= BLOCKS_B) begin
						chk_valid_s1        <= 1'b0;
						res_q.granted_block <= GRANT_NONE;
						res_q.status        <= ST_FULL;
						state_q             <= S_RESP;
					end else begin
						chk_valid_s1 <= 1'b1;
						chk_first_s1 <= first_q;
						chk_word_s1  <= rd_word_q;
						chk_base_s1  <= rd_base_q;
						first_q      <= 1'b0;
						rd_word_q    <= rd_word_q + 1'b1;
						rd_base_q    <= rd_base_q + BW'(WORD_BITS);
					end
				end
				S_FREE_RD: begin
					state_q <= S_FREE_WR;
				end
				S_FREE_WR: begin
					res_q.granted_block <= GRANT_NONE;
					res_q.status        <= ST_FREED;
					state_q             <= S_RESP;
				end
				S_RESP: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	// No request is taken while the bitmap is still being cleared.
	`BBA_ASSERT_NOW(a_no_accept_in_clear, state_q == S_CLEAR, !req_ready, "request accepted during clearing pass")
	// An accepted beat always starts the start-position division.
	`BBA_ASSERT_NEXT(a_accept_starts_div, req_valid && req_ready, state_q == S_DIV1 && !req_ready, "accepted beat did not start processing")
	// The reciprocal estimate leaves a remainder below twice the word size.
	`BBA_ASSERT_NOW(a_remainder_bound, state_q == S_DIV3, r_raw < GRANT_W'(2 * WORD_BITS), "start offset correction out of range")
	// Every answer other than a grant carries the no-block value.
	`BBA_ASSERT_NOW(a_none_on_non_grant, rsp_valid && rsp.status != ST_ALLOCATED, rsp.granted_block == GRANT_NONE, "non-grant result carries a block number")

endmodule

@@ dv/block_bitmap_allocator_tb.sv @@
module block_bitmap_allocator_tb
	import bba_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	// Sizes of the block as built here: 32768 blocks kept in 1024 words of 32 bits.
	localparam int NUM_BLOCKS = 32768;
	localparam int WORD_W     = 32;
	localparam int NUM_WORDS  = NUM_BLOCKS / WORD_W;
	localparam int TOP_BLOCK  = NUM_BLOCKS - 1;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	req_t                req       = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	rsp_t                rsp;
	logic                cfg_we    = 1'b0;
	logic [BLK_IN_W-1:0] cfg_wdata = '0;

	block_bitmap_allocator #(
		.BLOCKS   (NUM_BLOCKS),
		.WORD_BITS(WORD_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// Our own copy of the used/free bitmap and of the start register.
	logic [WORD_W-1:0]   used_words [NUM_WORDS];
	logic [BLK_IN_W-1:0] first_block_shadow = '0;

	// Request beats still to be offered, and answers owed by the block in order.
	req_t beats_pending [$];
	rsp_t grants_due    [$];

	// Handshake pacing. The idle switches are changed only between phases.
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	bit rx_hold    = 1'b0;
	int gap_left   = 0;
	int stall_left = 0;
	int rx_wait;

	// Bookkeeping for the verdict and the closing summary.
	int   mismatches   = 0;
	int   beats_seen   = 0;
	int   allocs_sent  = 0;
	int   frees_sent   = 0;
	int   full_answers = 0;
	int   cfg_writes   = 0;
	rsp_t want;

	// Works out the answer to one request beat and updates the shadow bitmap. An
	// allocate walks upward from the start register, skipping whole words that are
	// completely used, and takes the first clear bit. A free clears its bit plainly,
	// so freeing a block that is already free leaves it free and still answers freed.
	function automatic rsp_t grant_for_request(req_t beat);
		rsp_t        outcome;
		int unsigned blk;
		outcome.granted_block = GRANT_W'(NUM_BLOCKS);
		outcome.status        = ST_FULL;
		if (beat.opcode == OP_ALLOC) begin
			blk = first_block_shadow;
			while (blk < NUM_BLOCKS) begin
				if (blk % WORD_W == 0 && used_words[blk / WORD_W] == '1) begin
					blk += WORD_W;
				end else if (!used_words[blk / WORD_W][blk % WORD_W]) begin
					used_words[blk / WORD_W][blk % WORD_W] = 1'b1;
					outcome.granted_block = GRANT_W'(blk);
					outcome.status        = ST_ALLOCATED;
					return outcome;
				end else begin
					blk++;
				end
			end
		end else if (beat.blk_num >= NUM_BLOCKS) begin
			// A free past the end of the store changes nothing.
			outcome.status = ST_REJECTED;
		end else begin
			used_words[beat.blk_num / WORD_W][beat.blk_num % WORD_W] = 1'b0;
			outcome.status = ST_FREED;
		end
		return outcome;
	endfunction

	// Request driver. A beat that is on offer stays there, unchanged, until the
	// block takes it. After each accepted beat the driver may idle for a drawn
	// number of cycles before it offers the next one. The answer is predicted at
	// the edge that accepts the beat, so the shadow state follows accept order.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			gap_left  <= 0;
		end else begin
			if (req_valid && req_ready) begin
				grants_due.push_back(grant_for_request(req));
				if (req.opcode == OP_ALLOC) begin
					allocs_sent++;
				end else begin
					frees_sent++;
				end
			end
			if (!(req_valid && !req_ready)) begin
				if (gap_left != 0) begin
					req_valid <= 1'b0;
					gap_left  <= gap_left - 1;
				end else if (beats_pending.size() != 0) begin
					req       <= beats_pending.pop_front();
					req_valid <= 1'b1;
					gap_left  <= tx_idle_on ? $urandom_range(0, 6) : 0;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor. Every accepted beat is checked against the oldest answer
	// owed. After each beat the receiver may hold ready low for a drawn number of
	// cycles; the long hold below overrides it.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				beats_seen++;
				if (grants_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: response beat with nothing owed: block %0d status %0d",
							$realtime, rsp.granted_block, rsp.status);
					end
				end else begin
					want = grants_due.pop_front();
					if (want.status == ST_FULL) begin
						full_answers++;
					end
					if (rsp.granted_block !== want.granted_block || rsp.status !== want.status) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: granted_block expected %0d got %0d, status expected %0d got %0d",
								$realtime, want.granted_block, rsp.granted_block,
								want.status, rsp.status);
						end
					end
				end
				rx_wait = rx_idle_on ? $urandom_range(0, 6) : 0;
			end else begin
				rx_wait = (stall_left > 0) ? stall_left - 1 : 0;
			end
			stall_left <= rx_wait;
			rsp_ready  <= (rx_wait == 0) && !rx_hold;
		end
	end

	// Long receiver hold. While it lasts the driver keeps offering beats, so the
	// output register fills and the block has to push back on its request side.
	initial begin
		wait (beats_seen >= 300);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (400) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Waits until every queued beat has been taken and every owed answer has come.
	task automatic wait_drained();
		do begin
			@(posedge clk);
		end while (beats_pending.size() != 0 || req_valid || grants_due.size() != 0);
	endtask

	// Starts a new phase: lets the block settle, writes the start register and
	// picks whether both sides idle during the phase.
	task automatic start_phase(logic [BLK_IN_W-1:0] first_block, bit with_idles);
		wait_drained();
		repeat (16) @(posedge clk);
		cfg_we             <= 1'b1;
		cfg_wdata          <= first_block;
		first_block_shadow  = first_block;
		cfg_writes++;
		@(posedge clk);
		cfg_we     <= 1'b0;
		tx_idle_on  = with_idles;
		rx_idle_on  = with_idles;
	endtask

	task automatic queue_beat(opcode_t op, logic [BLK_IN_W-1:0] blk);
		req_t item;
		item.opcode  = op;
		item.blk_num = blk;
		beats_pending.push_back(item);
	endtask

	// Random traffic. Most frees aim just above the start register, where the
	// allocates have been filling upward, so they mostly hit used blocks; the
	// rest name any block at all. Allocates carry a random, ignored block field.
	task automatic queue_random(int unsigned count);
		int unsigned pick;
		int unsigned target;
		for (int unsigned i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 58) begin
				queue_beat(OP_ALLOC, BLK_IN_W'($urandom));
			end else if (pick < 92) begin
				target = first_block_shadow + $urandom_range(0, 95);
				if (target > TOP_BLOCK) begin
					target = TOP_BLOCK - $urandom_range(0, 63);
				end
				queue_beat(OP_FREE, BLK_IN_W'(target));
			end else begin
				queue_beat(OP_FREE, BLK_IN_W'($urandom));
			end
		end
	endtask

	initial begin
		foreach (used_words[w]) begin
			used_words[w] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// The start register keeps its reset value of zero here. Allocates hand out
		// 0, 1, 2 in order and a freed block is reused first. Freeing a block that is
		// already free, and freeing the top block, both answer freed.
		queue_beat(OP_ALLOC, 15'h7fff);
		queue_beat(OP_ALLOC, 15'h0000);
		queue_beat(OP_ALLOC, 15'h2aaa);
		queue_beat(OP_FREE, 15'd1);
		queue_beat(OP_ALLOC, 15'h5555);
		queue_beat(OP_FREE, 15'd1);
		queue_beat(OP_FREE, 15'd1);
		queue_beat(OP_FREE, 15'h7fff);
		queue_beat(OP_FREE, 15'd0);

		// Start at the very last block: one grant, then the store is full. A free
		// below the start register is still honored.
		start_phase(15'h7fff, 1'b1);
		queue_beat(OP_ALLOC, 15'd0);
		queue_beat(OP_ALLOC, 15'd0);
		queue_beat(OP_FREE, 15'h7fff);
		queue_beat(OP_ALLOC, 15'd0);
		queue_beat(OP_FREE, 15'd2);
		queue_beat(OP_ALLOC, 15'd0);

		// Fill the tail of the last word, then run out.
		start_phase(15'd32760, 1'b1);
		repeat (8) begin
			queue_beat(OP_ALLOC, BLK_IN_W'($urandom));
		end

		// Random phases over a range of start settings, one of them with no idling.
		start_phase(15'd0, 1'b0);
		queue_random(300);
		start_phase(BLK_IN_W'($urandom_range(64, 30000)), 1'b1);
		queue_random(280);
		start_phase(15'h7fff, 1'b1);
		queue_random(60);
		start_phase(BLK_IN_W'(NUM_BLOCKS - 48), 1'b1);
		queue_random(250);
		start_phase(15'd1, 1'b1);
		queue_random(250);
		start_phase(BLK_IN_W'($urandom), $urandom_range(0, 1) == 1);
		queue_random(290);

		wait_drained();
		repeat (40) @(posedge clk);

		$display("Covered %0d allocate and %0d free beats over %0d start settings,",
			allocs_sent, frees_sent, cfg_writes + 1);
		$display("with %0d out-of-space answers and %0d answers still owed at the end.",
			full_answers, grants_due.size());
		if (mismatches == 0 && grants_due.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Safety net against a hung handshake.
	initial begin
		#100ms;
		$display("Timed out with %0d beats queued and %0d answers owed.",
			beats_pending.size(), grants_due.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
